/* sv/cctk_pkg.sv */
`default_nettype none
package cctk_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_op;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
    } t_cal;

    localparam logic [10:0] MS_PER_SEC   = 11'd1000;
    localparam logic [9:0]  MAX_READING  = 10'd999;
    localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
    localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
    localparam logic [5:0]  HOUR_PER_DAY = 6'd24;
    localparam logic [4:0]  MONTHS       = 5'd12;

    localparam logic [15:0] RESET_YEAR   = 16'd1970;
    localparam logic [3:0]  RESET_MONTH  = 4'd1;
    localparam logic [4:0]  RESET_DAY    = 5'd1;

endpackage
`default_nettype wire

/* sv/cctk_advance.sv */
`default_nettype none
// Adds elapsed milliseconds and ripples one second carry up to the year.
module cctk_advance (
    input  var cctk_pkg::t_cal i_cal,
    input  wire logic [9:0]    i_add,
    output var cctk_pkg::t_cal o_cal
);

    // 25 * 23593 == 1 mod 2^16; multiples of 25 map onto 0..2621
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    logic [15:0] w_prod;
    logic        w_div25;
    logic        w_leap;
    logic [5:0]  w_dim;
    logic [10:0] w_sum;
    logic        w_carry;
    logic [6:0]  w_sec;
    logic        w_sec_wrap;
    logic [6:0]  w_min;
    logic        w_min_wrap;
    logic [5:0]  w_hour;
    logic        w_hour_wrap;
    logic [5:0]  w_day;
    logic        w_day_wrap;
    logic [4:0]  w_mon;
    logic        w_mon_wrap;

    assign w_prod  = i_cal.year * INV25;
    assign w_div25 = (w_prod <= DIV25_MAX);
    assign w_leap  = (i_cal.year[1:0] == 2'd0) && (!w_div25 || (i_cal.year[3:0] == 4'd0));

    always_comb begin
        case (i_cal.month)
            4'd4, 4'd6, 4'd9, 4'd11: w_dim = 6'd30;
            4'd2:                    w_dim = w_leap ? 6'd29 : 6'd28;
            default:                 w_dim = 6'd31;
        endcase
    end

    assign w_sum   = {1'b0, i_cal.millis} + {1'b0, i_add};
    assign w_carry = (w_sum >= cctk_pkg::MS_PER_SEC);

    assign w_sec       = {1'b0, i_cal.second} + 7'd1;
    assign w_sec_wrap  = (w_sec >= cctk_pkg::SEC_PER_MIN);
    assign w_min       = {1'b0, i_cal.minute} + {6'd0, w_sec_wrap};
    assign w_min_wrap  = (w_min >= cctk_pkg::MIN_PER_HOUR);
    assign w_hour      = {1'b0, i_cal.hour} + {5'd0, w_min_wrap};
    assign w_hour_wrap = (w_hour >= cctk_pkg::HOUR_PER_DAY);
    assign w_day       = {1'b0, i_cal.day} + 6'd1;
    assign w_day_wrap  = w_hour_wrap && (w_day > w_dim);
    assign w_mon       = {1'b0, i_cal.month} + 5'd1;
    assign w_mon_wrap  = w_day_wrap && (w_mon > cctk_pkg::MONTHS);

    always_comb begin
        o_cal = i_cal;
        if (w_carry) begin
            o_cal.millis = 10'(w_sum - cctk_pkg::MS_PER_SEC);
            o_cal.second = w_sec_wrap ? 6'd0 : w_sec[5:0];
            o_cal.minute = w_min_wrap ? 6'd0 : w_min[5:0];
            o_cal.hour   = w_hour_wrap ? 5'd0 : w_hour[4:0];
            if (w_hour_wrap) begin
                o_cal.day = w_day_wrap ? cctk_pkg::RESET_DAY : w_day[4:0];
            end
            if (w_day_wrap) begin
                o_cal.month = w_mon_wrap ? cctk_pkg::RESET_MONTH : w_mon[3:0];
            end
            if (w_mon_wrap) begin
                o_cal.year = i_cal.year + 16'd1;
            end
        end else begin
            o_cal.millis = w_sum[9:0];
        end
    end

endmodule
`default_nettype wire

/* sv/calendar_clock_ms_tick.sv */
// Calendar clock counting from a free-running millisecond reading.
// Input channel (i_in_valid / o_in_ready): one operation per transaction,
// i_op selects tick, set time, start or stop; i_ms_reading is used by tick
// and start, the i_set_* fields by set time.
// Output channel (o_out_valid / i_out_ready): every input transaction gives
// exactly one result, the date and time after the operation plus the run flag.
// Each transaction passes through the input register and then the result
// register. Throughput is one transaction per cycle while results are
// taken; the date update is a single pass of the carry chain (one 16-bit
// multiply for the leap test). When the receiver stalls, the result is held,
// one more transaction waits in the input register, and o_in_ready then drops
// until the result is taken. Reset (synchronous, active low) empties both
// registers and gives 1970-01-01 00:00:00.000 with the clock stopped.
`default_nettype none
module calendar_clock_ms_tick (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output var  logic        o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_ms_reading,
    input  wire logic [15:0] i_set_year,
    input  wire logic [3:0]  i_set_month,
    input  wire logic [4:0]  i_set_day,
    input  wire logic [4:0]  i_set_hour,
    input  wire logic [5:0]  i_set_minute,
    input  wire logic [5:0]  i_set_second,
    output var  logic        o_out_valid,
    input  wire logic        i_out_ready,
    output var  logic [15:0] o_cur_year,
    output var  logic [3:0]  o_cur_month,
    output var  logic [4:0]  o_cur_day,
    output var  logic [4:0]  o_cur_hour,
    output var  logic [5:0]  o_cur_minute,
    output var  logic [5:0]  o_cur_second,
    output var  logic [9:0]  o_cur_millis,
    output var  logic        o_is_running
);

    logic             r_in_valid;
    cctk_pkg::t_op    r_in_op;
    logic [9:0]       r_in_reading;
    cctk_pkg::t_cal   r_in_set;

    cctk_pkg::t_cal   r_cal, n_cal;
    logic [9:0]       r_last, n_last;
    logic             r_run, n_run;

    logic             r_out_valid;
    cctk_pkg::t_cal   r_out_cal;
    logic             r_out_run;

    logic             w_adv;
    logic             w_in_take;
    logic [9:0]       w_rd;
    logic [9:0]       w_elapsed;
    cctk_pkg::t_cal   w_ticked;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (w_in_take) begin
            r_in_op         <= cctk_pkg::t_op'(i_op);
            r_in_reading    <= i_ms_reading;
            r_in_set.year   <= i_set_year;
            r_in_set.month  <= i_set_month;
            r_in_set.day    <= i_set_day;
            r_in_set.hour   <= i_set_hour;
            r_in_set.minute <= i_set_minute;
            r_in_set.second <= i_set_second;
            r_in_set.millis <= 10'd0;
        end
    end

    assign w_rd      = (r_in_reading > cctk_pkg::MAX_READING) ? cctk_pkg::MAX_READING
                                                              : r_in_reading;
    assign w_elapsed = (w_rd >= r_last) ? (w_rd - r_last)
                                        : 10'(cctk_pkg::MS_PER_SEC - {1'b0, r_last}
                                              + {1'b0, w_rd});

    cctk_advance u_advance (
        .i_cal (r_cal),
        .i_add (w_elapsed),
        .o_cal (w_ticked)
    );

    always_comb begin
        n_cal  = r_cal;
        n_last = r_last;
        n_run  = r_run;
        case (r_in_op)
            cctk_pkg::OP_TICK: begin
                if (r_run) begin
                    n_cal  = w_ticked;
                    n_last = w_rd;
                end
            end
            cctk_pkg::OP_SET: begin
                n_cal = r_in_set;
            end
            cctk_pkg::OP_START: begin
                if (!r_run) begin
                    n_run  = 1'b1;
                    n_last = w_rd;
                end
            end
            cctk_pkg::OP_STOP: begin
                n_run = 1'b0;
            end
            default: begin
                n_run = r_run;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.year   <= cctk_pkg::RESET_YEAR;
            r_cal.month  <= cctk_pkg::RESET_MONTH;
            r_cal.day    <= cctk_pkg::RESET_DAY;
            r_cal.hour   <= 5'd0;
            r_cal.minute <= 6'd0;
            r_cal.second <= 6'd0;
            r_cal.millis <= 10'd0;
            r_last       <= 10'd0;
            r_run        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_adv) begin
                r_cal  <= n_cal;
                r_last <= n_last;
                r_run  <= n_run;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_adv) begin
            r_out_cal <= n_cal;
            r_out_run <= n_run;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cur_year   = r_out_cal.year;
    assign o_cur_month  = r_out_cal.month;
    assign o_cur_day    = r_out_cal.day;
    assign o_cur_hour   = r_out_cal.hour;
    assign o_cur_minute = r_out_cal.minute;
    assign o_cur_second = r_out_cal.second;
    assign o_cur_millis = r_out_cal.millis;
    assign o_is_running = r_out_run;

endmodule
`default_nettype wire

/* sv/cctk_checker.sv */
`default_nettype none
module cctk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_cur_year,
    input wire logic [9:0]  o_cur_millis,
    input wire logic        o_is_running
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_cur_millis) && $stable(o_cur_year)
            && $stable(o_is_running))
        else $error("result changed while stalled");

    a_millis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cur_millis < 10'd1000)
        else $error("milliseconds out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // empty result register never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind calendar_clock_ms_tick cctk_checker u_cctk_checker (.*);
`default_nettype wire

/* dv/tb_calendar_clock_ms_tick.sv */
`timescale 1ns / 1ps
module tb_calendar_clock_ms_tick;

    localparam int N_RANDOM    = 1400;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 50;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        cctk_pkg::t_cal cal;
        logic           run;
    } t_res;

    typedef struct packed {
        cctk_pkg::t_op  op;
        logic [9:0]     rd;
        cctk_pkg::t_cal load;
        logic           chk;
        cctk_pkg::t_cal exp_cal;
        logic           exp_run;
    } t_stim;

    typedef struct {
        int unsigned ms, sec, min, hr, day, mon, yr, last;
        bit          run;
    } t_clk;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [9:0]  i_ms_reading;
    logic [15:0] i_set_year;
    logic [3:0]  i_set_month;
    logic [4:0]  i_set_day;
    logic [4:0]  i_set_hour;
    logic [5:0]  i_set_minute;
    logic [5:0]  i_set_second;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_cur_year;
    logic [3:0]  o_cur_month;
    logic [4:0]  o_cur_day;
    logic [4:0]  o_cur_hour;
    logic [5:0]  o_cur_minute;
    logic [5:0]  o_cur_second;
    logic [9:0]  o_cur_millis;
    logic        o_is_running;

    t_stim stim_q[$];
    t_res  due_q[$];
    t_clk  clk_st;
    int    n_items;
    int    in_count  = 0;
    int    out_count = 0;
    int    stall_cnt = 0;
    int    n_err     = 0;
    int    n_month_roll = 0;
    int    n_year_roll  = 0;
    int    op_seen[4]   = '{0, 0, 0, 0};

    calendar_clock_ms_tick u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_ms_reading (i_ms_reading),
        .i_set_year   (i_set_year),
        .i_set_month  (i_set_month),
        .i_set_day    (i_set_day),
        .i_set_hour   (i_set_hour),
        .i_set_minute (i_set_minute),
        .i_set_second (i_set_second),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cur_year   (o_cur_year),
        .o_cur_month  (o_cur_month),
        .o_cur_day    (o_cur_day),
        .o_cur_hour   (o_cur_hour),
        .o_cur_minute (o_cur_minute),
        .o_cur_second (o_cur_second),
        .o_cur_millis (o_cur_millis),
        .o_is_running (o_is_running)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic cctk_pkg::t_cal mk_time(int y, int mo, int d, int h, int mi, int s,
                                               int ms);
        cctk_pkg::t_cal t;
        t.year   = 16'(y);
        t.month  = 4'(mo);
        t.day    = 5'(d);
        t.hour   = 5'(h);
        t.minute = 6'(mi);
        t.second = 6'(s);
        t.millis = 10'(ms);
        return t;
    endfunction

    function automatic t_stim dir_row(cctk_pkg::t_op op, int rd, cctk_pkg::t_cal load,
                                      bit chk, cctk_pkg::t_cal e, bit er);
        t_stim it;
        it.op      = op;
        it.rd      = 10'(rd);
        it.load    = load;
        it.chk     = chk;
        it.exp_cal = e;
        it.exp_run = er;
        return it;
    endfunction

    // Predicted date/time after one operation; updates clk_st.
    function automatic t_res step_clock(cctk_pkg::t_op op, logic [9:0] raw,
                                        cctk_pkg::t_cal load);
        int unsigned rd;
        t_res        r;
        rd = (raw > cctk_pkg::MAX_READING) ? cctk_pkg::MAX_READING : raw;
        case (op)
            cctk_pkg::OP_TICK: begin
                if (clk_st.run) begin
                    clk_st.ms += (rd >= clk_st.last) ? rd - clk_st.last
                                 : cctk_pkg::MS_PER_SEC - clk_st.last + rd;
                    clk_st.last = rd;
                    while (clk_st.ms >= cctk_pkg::MS_PER_SEC) begin
                        clk_st.ms -= cctk_pkg::MS_PER_SEC;
                        clk_st.sec++;
                        if (clk_st.sec >= cctk_pkg::SEC_PER_MIN) begin
                            clk_st.sec = 0;
                            clk_st.min++;
                        end
                        if (clk_st.min >= cctk_pkg::MIN_PER_HOUR) begin
                            clk_st.min = 0;
                            clk_st.hr++;
                        end
                        if (clk_st.hr >= cctk_pkg::HOUR_PER_DAY) begin
                            clk_st.hr = 0;
                            clk_st.day++;
                            if (clk_st.day > days_in_month(clk_st.yr, clk_st.mon)) begin
                                clk_st.day = 1;
                                clk_st.mon++;
                                n_month_roll++;
                                if (clk_st.mon > cctk_pkg::MONTHS) begin
                                    clk_st.mon = 1;
                                    clk_st.yr  = (clk_st.yr + 1) & 16'hFFFF;
                                    n_year_roll++;
                                end
                            end
                        end
                    end
                end
            end
            cctk_pkg::OP_SET: begin
                clk_st.yr  = load.year;
                clk_st.mon = load.month;
                clk_st.day = load.day;
                clk_st.hr  = load.hour;
                clk_st.min = load.minute;
                clk_st.sec = load.second;
                clk_st.ms  = 0;
            end
            cctk_pkg::OP_START: begin
                if (!clk_st.run) begin
                    clk_st.run  = 1'b1;
                    clk_st.last = rd;
                end
            end
            default: clk_st.run = 1'b0;
        endcase
        r.cal.year   = 16'(clk_st.yr);
        r.cal.month  = 4'(clk_st.mon);
        r.cal.day    = 5'(clk_st.day);
        r.cal.hour   = 5'(clk_st.hr);
        r.cal.minute = 6'(clk_st.min);
        r.cal.second = 6'(clk_st.sec);
        r.cal.millis = 10'(clk_st.ms);
        r.run        = clk_st.run;
        return r;
    endfunction

    // Input side: send stim_q in order, random gaps by phase.
    initial begin : drive_in
        int  nxt;
        int  ph;
        bit  acc;
        i_in_valid   <= 1'b0;
        i_op         <= cctk_pkg::OP_TICK;
        i_ms_reading <= '0;
        i_set_year   <= '0;
        i_set_month  <= '0;
        i_set_day    <= '0;
        i_set_hour   <= '0;
        i_set_minute <= '0;
        i_set_second <= '0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            acc = i_in_valid && o_in_ready;
            nxt = in_count + int'(acc);
            ph  = in_count * 3 / n_items;
            if (!i_in_valid || acc) begin
                if (nxt < n_items &&
                    $urandom_range(99) >= (ph == 0 ? 19 : ph == 1 ? 49 : 0)) begin
                    i_op         <= stim_q[nxt].op;
                    i_ms_reading <= stim_q[nxt].rd;
                    i_set_year   <= stim_q[nxt].load.year;
                    i_set_month  <= stim_q[nxt].load.month;
                    i_set_day    <= stim_q[nxt].load.day;
                    i_set_hour   <= stim_q[nxt].load.hour;
                    i_set_minute <= stim_q[nxt].load.minute;
                    i_set_second <= stim_q[nxt].load.second;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output side: random stalls by phase, one long hold-off to back up the input.
    initial begin : drain_out
        int ph;
        bit held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            ph = in_count * 3 / n_items;
            if (!held && in_count >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= (ph == 0 ? 49 : ph == 1 ? 19 : 0));
            end
        end
    end

    always @(posedge i_clk) begin : take_in
        cctk_pkg::t_cal load;
        t_res r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            load.year   = i_set_year;
            load.month  = i_set_month;
            load.day    = i_set_day;
            load.hour   = i_set_hour;
            load.minute = i_set_minute;
            load.second = i_set_second;
            load.millis = '0;
            r = step_clock(cctk_pkg::t_op'(i_op), i_ms_reading, load);
            if (stim_q[in_count].chk) begin
                r.cal = stim_q[in_count].exp_cal;
                r.run = stim_q[in_count].exp_run;
            end
            due_q.push_back(r);
            op_seen[i_op]++;
            in_count <= in_count + 1;
        end
    end

    always @(posedge i_clk) begin : check_out
        t_res a;
        t_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            a.cal.year   = o_cur_year;
            a.cal.month  = o_cur_month;
            a.cal.day    = o_cur_day;
            a.cal.hour   = o_cur_hour;
            a.cal.minute = o_cur_minute;
            a.cal.second = o_cur_second;
            a.cal.millis = o_cur_millis;
            a.run        = o_is_running;
            out_count <= out_count + 1;
            if (due_q.size() == 0) begin
                n_err++;
                if (n_err <= MAX_REPORTS)
                    $display("ERROR: unexpected result transaction %0d at %0t",
                             out_count, $realtime);
            end else begin
                e = due_q.pop_front();
                if (a.cal.year != e.cal.year || a.cal.month != e.cal.month ||
                    a.cal.day != e.cal.day || a.cal.hour != e.cal.hour ||
                    a.cal.minute != e.cal.minute || a.cal.second != e.cal.second ||
                    a.cal.millis != e.cal.millis || a.run != e.run) begin
                    n_err++;
                    if (n_err <= MAX_REPORTS) begin
                        $display("ERROR: result %0d exp %0d-%0d-%0d %0d:%0d:%0d.%0d run %0b",
                                 out_count,
                                 e.cal.year, e.cal.month, e.cal.day, e.cal.hour,
                                 e.cal.minute, e.cal.second, e.cal.millis, e.run);
                        $display("       got %0d-%0d-%0d %0d:%0d:%0d.%0d run %0b",
                                 a.cal.year, a.cal.month, a.cal.day, a.cal.hour,
                                 a.cal.minute, a.cal.second, a.cal.millis, a.run);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : run_test
        t_stim          it;
        int             pick;
        int unsigned    y;
        int unsigned    m;
        cctk_pkg::t_cal none;
        cctk_pkg::t_cal rst_cal;
        none = '0;
        rst_cal = mk_time(cctk_pkg::RESET_YEAR, cctk_pkg::RESET_MONTH, cctk_pkg::RESET_DAY,
                          0, 0, 0, 0);
        i_rst_n <= 1'b0;

        // directed: reset state, redundant start/stop, rollovers, raw set values
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 500, none, 1'b1, rst_cal, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_STOP, 0, none, 1'b1, rst_cal, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(2023, 12, 31, 23, 59, 59, 0),
            1'b1, mk_time(2023, 12, 31, 23, 59, 59, 0), 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_START, 100, none, 1'b1,
            mk_time(2023, 12, 31, 23, 59, 59, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_START, 900, none, 1'b1,
            mk_time(2023, 12, 31, 23, 59, 59, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 1023, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 99, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 100, none, 1'b1,
            mk_time(2024, 1, 1, 0, 0, 0, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(2024, 2, 28, 23, 59, 59, 0),
            1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 99, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 100, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(2100, 2, 28, 23, 59, 59, 0),
            1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 99, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 100, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(65535, 12, 31, 23, 59, 59, 0),
            1'b1, mk_time(65535, 12, 31, 23, 59, 59, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 99, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 100, none, 1'b1,
            mk_time(0, 1, 1, 0, 0, 0, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(0, 15, 31, 31, 63, 63, 0),
            1'b1, mk_time(0, 15, 31, 31, 63, 63, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 99, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 100, none, 1'b0, none, 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_SET, 0, mk_time(0, 0, 0, 0, 0, 0, 0), 1'b1,
            mk_time(0, 0, 0, 0, 0, 0, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_STOP, 0, none, 1'b1,
            mk_time(0, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 0, none, 1'b1,
            mk_time(0, 0, 0, 0, 0, 0, 0), 1'b0));
        stim_q.push_back(dir_row(cctk_pkg::OP_START, 0, none, 1'b1,
            mk_time(0, 0, 0, 0, 0, 0, 0), 1'b1));
        stim_q.push_back(dir_row(cctk_pkg::OP_TICK, 0, none, 1'b1,
            mk_time(0, 0, 0, 0, 0, 0, 0), 1'b1));

        // random: mostly ticks, sets biased to just before a day/month/year rollover
        for (int k = 0; k < N_RANDOM; k++) begin
            it = '0;
            it.rd = ($urandom_range(15) == 0) ? 10'($urandom_range(1023, 1000))
                                              : 10'($urandom_range(999));
            pick = $urandom_range(99);
            if (pick < 70) begin
                it.op = cctk_pkg::OP_TICK;
            end else if (pick < 80) begin
                it.op = cctk_pkg::OP_START;
            end else if (pick < 85) begin
                it.op = cctk_pkg::OP_STOP;
            end else begin
                it.op = cctk_pkg::OP_SET;
                pick = $urandom_range(9);
                case ($urandom_range(3))
                    0:       y = $urandom_range(65535);
                    1:       y = 4 * $urandom_range(16383);
                    2:       y = 100 * $urandom_range(655);
                    default: y = $urandom_range(65535, 65532);
                endcase
                m = $urandom_range(12, 1);
                if (pick < 7) begin
                    it.load = mk_time(y, m, days_in_month(y, m) - ($urandom_range(3) == 0),
                                      23, 59, $urandom_range(59, 58), 0);
                end else if (pick < 9) begin
                    it.load = mk_time(y, m, $urandom_range(days_in_month(y, m), 1),
                                      $urandom_range(23), $urandom_range(59),
                                      $urandom_range(59), 0);
                end else begin
                    it.load = mk_time($urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, 0);
                end
            end
            stim_q.push_back(it);
        end
        n_items = stim_q.size();

        clk_st = '{ms: 0, sec: 0, min: 0, hr: 0, day: cctk_pkg::RESET_DAY,
                   mon: cctk_pkg::RESET_MONTH, yr: cctk_pkg::RESET_YEAR, last: 0,
                   run: 1'b0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (in_count < n_items) @(posedge i_clk);
        while (due_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Run: %0d operations (tick %0d, set %0d, start %0d, stop %0d), %0d results",
                 in_count, op_seen[cctk_pkg::OP_TICK], op_seen[cctk_pkg::OP_SET],
                 op_seen[cctk_pkg::OP_START], op_seen[cctk_pkg::OP_STOP], out_count);
        $display("Calendar: %0d month and %0d year rollovers predicted, %0d mismatches",
                 n_month_roll, n_year_roll, n_err);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
